>>> src/bilinear_image_resize_unit_assert.svh
// Assertion macros shared by the bilinear resize RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define BIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define BIR_NEVER(label, cond, msg) \
  `BIR_ASSERT(label, !(cond), msg)

`endif

>>> src/bir_pkg.sv
// Package for the bilinear resize unit: widths, register indexes, commands,
// configuration and queue item types. No dependencies.
`timescale 1ns / 1ps

package bir_pkg;

  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int PIX_W       = 32;
  localparam int NUM_LANES   = 4;
  localparam int IN_DIM_W    = 9;
  localparam int IN_DIM_MAX  = (1 << IN_DIM_W) - 1;
  localparam int DIM_W       = 13;
  localparam int OUT_DIM_MAX = 4096;
  localparam int CNT_W       = 12;
  localparam int CH_W        = 3;
  localparam int STEP_W      = 24;
  localparam int FRAC_W      = 16;
  localparam int POS_W       = CNT_W + STEP_W;
  localparam int INT_W       = POS_W - FRAC_W;
  localparam int FRAME_W     = 2 * IN_DIM_W;
  localparam int WT_W        = 2 * (FRAC_W + 1);
  localparam int ACC_W       = 8 + WT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

  localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHANNELS   = 3'd4;
  localparam logic [2:0] REG_X_STEP     = 3'd5;
  localparam logic [2:0] REG_Y_STEP     = 3'd6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic [IN_DIM_W-1:0] in_width;
    logic [IN_DIM_W-1:0] in_height;
    logic [DIM_W-1:0]    out_width;
    logic [DIM_W-1:0]    out_height;
    logic [CH_W-1:0]     channels;
    logic [STEP_W-1:0]   x_step;
    logic [STEP_W-1:0]   y_step;
  } cfg_t;

  // One classified item: a store write (addr[0], data) or the four
  // neighbor addresses and fractions of one output pixel.
  typedef struct packed {
    logic                               cmd;
    logic                               last;
    logic [NUM_LANES-1:0][STORE_AW-1:0] addr;
    logic [PIX_W-1:0]                   data;
    logic [FRAC_W-1:0]                  fx;
    logic [FRAC_W-1:0]                  fy;
  } entry_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][7:0] chan;
    logic                      last;
  } result_t;

endpackage

>>> src/bir_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/bir_fifo.sv
// Small register FIFO with head visible at the read port.
// Uses the assertion macro header.
`timescale 1ns / 1ps
`include "bilinear_image_resize_unit_assert.svh"

module bir_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BIR_NEVER(fifo_overflow, push && full && !pop, "fifo push while full")
  `BIR_NEVER(fifo_underflow, pop && empty, "fifo pop while empty")

endmodule

>>> src/bir_front.sv
// Front end: accepts items, keeps the load and output counters, and turns
// each emit into four neighbor addresses and fractions. Uses bir_pkg.
`timescale 1ns / 1ps

module bir_front #(
  parameter int MAX_IN_WIDTH  = 256,
  parameter int MAX_IN_HEIGHT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bir_pkg::cfg_t                cfg,
  input  logic                         push,
  output logic                         full,
  input  logic                         command,
  input  logic [bir_pkg::PIX_W-1:0]    pixel,
  output logic                         q_push,
  output bir_pkg::entry_t              q_entry,
  input  logic                         q_full
);

  import bir_pkg::*;

  localparam int W_LIM = (MAX_IN_WIDTH > IN_DIM_MAX) ? IN_DIM_MAX : MAX_IN_WIDTH;
  localparam int H_LIM = (MAX_IN_HEIGHT > IN_DIM_MAX) ? IN_DIM_MAX : MAX_IN_HEIGHT;
  localparam logic [IN_DIM_W-1:0] W_MAX   = IN_DIM_W'(W_LIM);
  localparam logic [IN_DIM_W-1:0] H_MAX   = IN_DIM_W'(H_LIM);
  localparam logic [DIM_W-1:0]    OUT_MAX = DIM_W'(OUT_DIM_MAX);

  logic [STORE_AW-1:0] load_address;
  logic [CNT_W-1:0]    out_col;
  logic [CNT_W-1:0]    out_row;

  logic                f1_valid;
  logic                f1_cmd;
  logic                f1_last;
  logic [STORE_AW-1:0] f1_addr;
  logic [PIX_W-1:0]    f1_data;
  logic [CNT_W-1:0]    f1_col;
  logic [CNT_W-1:0]    f1_row;

  logic                f2_valid;
  logic                f2_cmd;
  logic                f2_last;
  logic [STORE_AW-1:0] f2_addr;
  logic [PIX_W-1:0]    f2_data;
  logic [POS_W-1:0]    f2_sx;
  logic [POS_W-1:0]    f2_sy;

  logic                en;
  logic                accept;
  logic [IN_DIM_W-1:0] w;
  logic [IN_DIM_W-1:0] h;
  logic [IN_DIM_W-1:0] wm1;
  logic [IN_DIM_W-1:0] hm1;
  logic [FRAME_W-1:0]  frame;
  logic [STORE_AW-1:0] load_inc;
  logic [STORE_AW-1:0] load_address_next;
  logic [DIM_W-1:0]    ow;
  logic [DIM_W-1:0]    oh;
  logic                last_col;
  logic                last_row;

  logic [INT_W-1:0]    ix;
  logic [INT_W-1:0]    iy;
  logic [INT_W:0]      ix1;
  logic [INT_W:0]      iy1;
  logic [IN_DIM_W-1:0] x0;
  logic [IN_DIM_W-1:0] x1;
  logic [IN_DIM_W-1:0] y0;
  logic [IN_DIM_W-1:0] y1;
  logic [FRAME_W-1:0]  base0;
  logic [FRAME_W-1:0]  base1;
  logic [FRAME_W-1:0]  sum_a;
  logic [FRAME_W-1:0]  sum_b;
  logic [FRAME_W-1:0]  sum_c;
  logic [FRAME_W-1:0]  sum_d;

  assign en     = !(f2_valid && q_full);
  assign full   = !en;
  assign accept = push && en;
  assign q_push = f2_valid && en;

  always_comb begin
    if (cfg.in_width == '0) begin
      w = IN_DIM_W'(1);
    end else if (cfg.in_width > W_MAX) begin
      w = W_MAX;
    end else begin
      w = cfg.in_width;
    end
    if (cfg.in_height == '0) begin
      h = IN_DIM_W'(1);
    end else if (cfg.in_height > H_MAX) begin
      h = H_MAX;
    end else begin
      h = cfg.in_height;
    end
    if (cfg.out_width == '0) begin
      ow = DIM_W'(1);
    end else if (cfg.out_width > OUT_MAX) begin
      ow = OUT_MAX;
    end else begin
      ow = cfg.out_width;
    end
    if (cfg.out_height == '0) begin
      oh = DIM_W'(1);
    end else if (cfg.out_height > OUT_MAX) begin
      oh = OUT_MAX;
    end else begin
      oh = cfg.out_height;
    end
  end

  assign wm1   = w - 1'b1;
  assign hm1   = h - 1'b1;
  assign frame = FRAME_W'(w) * FRAME_W'(h);

  assign load_inc          = load_address + 1'b1;
  assign load_address_next = ({{(FRAME_W - STORE_AW){1'b0}}, load_inc} >= frame) ? '0 : load_inc;

  assign last_col = ({1'b0, out_col} + DIM_W'(1)) >= ow;
  assign last_row = ({1'b0, out_row} + DIM_W'(1)) >= oh;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= '0;
      out_col      <= '0;
      out_row      <= '0;
      f1_valid     <= 1'b0;
      f2_valid     <= 1'b0;
    end else if (en) begin
      f1_valid <= accept;
      f2_valid <= f1_valid;
      if (accept) begin
        if (command == CMD_LOAD) begin
          load_address <= load_address_next;
        end else if (last_col) begin
          out_col <= '0;
          out_row <= last_row ? '0 : out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_cmd  <= command;
      f1_last <= last_col && last_row;
      f1_addr <= load_address;
      f1_data <= pixel;
      f1_col  <= out_col;
      f1_row  <= out_row;
      f2_cmd  <= f1_cmd;
      f2_last <= f1_last;
      f2_addr <= f1_addr;
      f2_data <= f1_data;
      f2_sx   <= POS_W'(f1_col) * POS_W'(cfg.x_step);
      f2_sy   <= POS_W'(f1_row) * POS_W'(cfg.y_step);
    end
  end

  assign ix  = f2_sx[POS_W-1:FRAC_W];
  assign iy  = f2_sy[POS_W-1:FRAC_W];
  assign ix1 = {1'b0, ix} + (INT_W + 1)'(1);
  assign iy1 = {1'b0, iy} + (INT_W + 1)'(1);

  assign x0 = (ix >= INT_W'(wm1)) ? wm1 : ix[IN_DIM_W-1:0];
  assign x1 = (ix1 >= (INT_W + 1)'(wm1)) ? wm1 : ix1[IN_DIM_W-1:0];
  assign y0 = (iy >= INT_W'(hm1)) ? hm1 : iy[IN_DIM_W-1:0];
  assign y1 = (iy1 >= (INT_W + 1)'(hm1)) ? hm1 : iy1[IN_DIM_W-1:0];

  assign base0 = FRAME_W'(y0) * FRAME_W'(w);
  assign base1 = FRAME_W'(y1) * FRAME_W'(w);
  assign sum_a = base0 + FRAME_W'(x0);
  assign sum_b = base0 + FRAME_W'(x1);
  assign sum_c = base1 + FRAME_W'(x0);
  assign sum_d = base1 + FRAME_W'(x1);

  always_comb begin
    q_entry.cmd  = f2_cmd;
    q_entry.last = f2_last;
    q_entry.data = f2_data;
    q_entry.fx   = f2_sx[FRAC_W-1:0];
    q_entry.fy   = f2_sy[FRAC_W-1:0];
    if (f2_cmd == CMD_LOAD) begin
      q_entry.addr[0] = f2_addr;
    end else begin
      q_entry.addr[0] = sum_a[STORE_AW-1:0];
    end
    q_entry.addr[1] = sum_b[STORE_AW-1:0];
    q_entry.addr[2] = sum_c[STORE_AW-1:0];
    q_entry.addr[3] = sum_d[STORE_AW-1:0];
  end

endmodule

>>> src/bir_back.sv
// Back end: writes loads into the pixel store and, per emit, reads four
// neighbors and accumulates weighted channels. Uses bir_pkg and the macro header.
`timescale 1ns / 1ps
`include "bilinear_image_resize_unit_assert.svh"

module bir_back #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bir_pkg::cfg_t                  cfg,
  input  logic                           q_empty,
  input  bir_pkg::entry_t                q_entry,
  output logic                           q_pop,
  input  logic [bir_pkg::OUT_CW-1:0]     out_count,
  output logic                           out_push,
  output bir_pkg::result_t               out_item,
  output logic                           ram_we,
  output logic [bir_pkg::STORE_AW-1:0]   ram_addr,
  output logic [bir_pkg::PIX_W-1:0]      ram_wdata,
  input  logic [bir_pkg::PIX_W-1:0]      ram_rdata
);

  import bir_pkg::*;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_READ = 1'b1;
  localparam logic [CH_W-1:0] CH_MAX = CH_W'(MAX_CHANNELS);
  localparam logic [FRAC_W:0] ONE    = (FRAC_W + 1)'(1 << FRAC_W);

  logic                 state;
  logic [1:0]           k;
  entry_t               em;
  logic [WT_W-1:0]      w_reg;
  logic                 p_valid;
  logic [1:0]           p_k;
  logic [NUM_LANES-1:0][ACC_W-1:0] acc;

  logic                 room;
  logic                 head_load;
  logic                 head_emit;
  logic                 issue;
  logic [1:0]           k_cur;
  entry_t               cur;
  logic [FRAC_W:0]      mx;
  logic [FRAC_W:0]      my;
  logic [CH_W-1:0]      nch;
  logic [NUM_LANES-1:0][ACC_W-1:0] sum;

  assign room      = out_count <= OUT_CW'(OUT_DEPTH - 2);
  assign head_load = !q_empty && state == B_IDLE && q_entry.cmd == CMD_LOAD;
  assign head_emit = !q_empty && state == B_IDLE && q_entry.cmd == CMD_EMIT && room;
  assign q_pop     = head_load || head_emit;
  assign issue     = head_emit || state == B_READ;
  assign k_cur     = (state == B_READ) ? k : 2'd0;
  assign cur       = (state == B_READ) ? em : q_entry;

  assign ram_we    = head_load;
  assign ram_wdata = q_entry.data;
  assign ram_addr  = head_load ? q_entry.addr[0] : cur.addr[k_cur];

  assign mx = k_cur[0] ? {1'b0, cur.fx} : ONE - {1'b0, cur.fx};
  assign my = k_cur[1] ? {1'b0, cur.fy} : ONE - {1'b0, cur.fy};

  assign nch = (cfg.channels > CH_MAX) ? CH_MAX : cfg.channels;

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      sum[c] = ((p_k == 2'd0) ? '0 : acc[c]) + ram_rdata[c*8 +: 8] * w_reg;
      out_item.chan[c] = (CH_W'(c) < nch) ? sum[c][2*FRAC_W +: 8] : 8'd0;
    end
    out_item.last = em.last;
  end

  assign out_push = p_valid && p_k == 2'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      k       <= 2'd0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
      if (head_emit) begin
        state <= B_READ;
        k     <= 2'd1;
      end else if (state == B_READ) begin
        k <= k + 1'b1;
        if (k == 2'd3) begin
          state <= B_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_emit) begin
      em <= q_entry;
    end
    if (issue) begin
      w_reg <= WT_W'(mx * my);
      p_k   <= k_cur;
    end
    if (p_valid) begin
      acc <= sum;
    end
  end

  `BIR_NEVER(out_no_overflow, out_push && out_count == OUT_CW'(OUT_DEPTH), "result fifo overrun")
  `BIR_ASSERT(read_no_write, (state == B_READ) |-> !ram_we, "store write during neighbor reads")
  `BIR_ASSERT(read_phase, (state == B_READ) |-> (k != 2'd0), "bad neighbor index in read phase")

endmodule

>>> src/bilinear_image_resize_unit.sv
// Bilinear image resize unit, top level. Uses bir_pkg and all bir_ modules.
// Load items take one store write each (one per cycle while the back end is idle);
// an emit reads its four neighbors in turn on the single-port pixel store, and
// the back end takes no new item until those reads are done.
// Reset clears counters, queues and registers; the pixel store is not cleared.
`timescale 1ns / 1ps

module bilinear_image_resize_unit #(
  parameter int MAX_IN_WIDTH  = 256,
  parameter int MAX_IN_HEIGHT = 256,
  parameter int MAX_CHANNELS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [7:0]  chan0_in,
  input  logic [7:0]  chan1_in,
  input  logic [7:0]  chan2_in,
  input  logic [7:0]  chan3_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  chan0_out,
  output logic [7:0]  chan1_out,
  output logic [7:0]  chan2_out,
  output logic [7:0]  chan3_out,
  output logic        last_pixel
);

  import bir_pkg::*;

  cfg_t                cfg;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  entry_t              q_in;
  entry_t              q_out;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  logic                out_push;
  logic                out_full;
  logic                out_pop;
  result_t             out_in;
  result_t             out_head;
  logic [OUT_CW-1:0]   out_count;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [PIX_W-1:0]    ram_wdata;
  logic [PIX_W-1:0]    ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_width   <= IN_DIM_W'(256);
      cfg.in_height  <= IN_DIM_W'(256);
      cfg.out_width  <= DIM_W'(256);
      cfg.out_height <= DIM_W'(256);
      cfg.channels   <= CH_W'(3);
      cfg.x_step     <= STEP_W'(65536);
      cfg.y_step     <= STEP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_WIDTH:   cfg.in_width   <= cfg_data[IN_DIM_W-1:0];
        REG_IN_HEIGHT:  cfg.in_height  <= cfg_data[IN_DIM_W-1:0];
        REG_OUT_WIDTH:  cfg.out_width  <= cfg_data[DIM_W-1:0];
        REG_OUT_HEIGHT: cfg.out_height <= cfg_data[DIM_W-1:0];
        REG_CHANNELS:   cfg.channels   <= cfg_data[CH_W-1:0];
        REG_X_STEP:     cfg.x_step     <= cfg_data[STEP_W-1:0];
        REG_Y_STEP:     cfg.y_step     <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bir_front #(
    .MAX_IN_WIDTH  (MAX_IN_WIDTH),
    .MAX_IN_HEIGHT (MAX_IN_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .command (command),
    .pixel   ({chan3_in, chan2_in, chan1_in, chan0_in}),
    .q_push  (q_push),
    .q_entry (q_in),
    .q_full  (q_full)
  );

  bir_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .pop   (q_pop),
    .rdata (q_out),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  bir_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (out_in),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  bir_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_pop = pop && !empty;

  bir_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_in),
    .pop   (out_pop),
    .rdata (out_head),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  assign chan0_out  = out_head.chan[0];
  assign chan1_out  = out_head.chan[1];
  assign chan2_out  = out_head.chan[2];
  assign chan3_out  = out_head.chan[3];
  assign last_pixel = out_head.last;

  `BIR_NEVER(queue_count_range, q_count > ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue count out of range")
  `BIR_NEVER(results_overrun, out_push && out_full && !out_pop, "result fifo full on push")

endmodule
